// ===== rtl/dcf_pkg.sv =====
package dcf_pkg;

   localparam int MaxVertices = 64;
   localparam int MaxClique   = 6;
   localparam int RowWidth    = 64;

   localparam logic [1:0] CsrCliqueSize  = 2'd0;
   localparam logic [1:0] CsrVertexCount = 2'd1;
   localparam logic [1:0] CsrEdgeColor   = 2'd2;

   localparam logic OpLoad   = 1'b0;
   localparam logic OpSearch = 1'b1;

   typedef struct packed {
      logic        op;
      logic [5:0]  row_index;
      logic [63:0] row_bits;
      logic [5:0]  label;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [2:0] member_count;
      logic [5:0] member_a;
      logic [5:0] member_b;
      logic [5:0] member_c;
      logic [5:0] member_d;
      logic [5:0] member_e;
      logic [5:0] member_f;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // write row, clear label
      logic init;       // build root candidate set
      logic step;       // one search step
      logic commit;     // write labels of found clique
      logic respond;    // present result
      logic fail;       // result is not found
   } dcf_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic valid_size; // size and vertex count allow a search
      logic hit;        // clique complete
      logic exhausted;  // search tree done
      logic commit_done;
   } dcf_sts_type;

endpackage

// ===== rtl/dcf_datapath.sv =====
module dcf_datapath #(
   parameter int MAX_VERTICES = dcf_pkg::MaxVertices,
   parameter int MAX_CLIQUE   = dcf_pkg::MaxClique
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dcf_pkg::req_type     req_item,
   input  logic [2:0]           clique_size,
   input  logic [6:0]           vertex_count,
   input  logic                 edge_color,
   input  dcf_pkg::dcf_cmd_type cmd,
   output dcf_pkg::dcf_sts_type sts,
   output logic                 rsp_strobe,
   output dcf_pkg::rsp_type     rsp_item
);
   import dcf_pkg::*;

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int DW = $clog2(MAX_CLIQUE + 1);

   logic [RowWidth-1:0] rows_mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] rows_valid_ff;
   logic [MAX_VERTICES-1:0] labelled_ff, labelled_in;

   // per-depth candidate sets and picks
   logic [RowWidth-1:0] cand_ff [MAX_CLIQUE+1];
   logic [5:0]          pick_ff [MAX_CLIQUE];
   logic [DW-1:0]       depth_ff, depth_in;
   logic [5:0]          label_ff;
   logic [DW-1:0]       cidx_ff;
   logic                rsp_strobe_ff;
   rsp_type             rsp_ff, rsp_in;

   // row read for the vertex picked last step (registered)
   logic [RowWidth-1:0] row_rd_ff;
   logic                row_ok_ff;
   logic [RowWidth-1:0] row_use;
   logic                row_pending_ff;

   logic [6:0] nv;
   logic       valid_size;
   logic       load_ok;
   logic [RowWidth-1:0] cur_cand, lowest_bit, above;
   logic [5:0] lowest_idx;
   logic       any_cand;

   assign nv = (vertex_count > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : vertex_count;
   assign valid_size = (clique_size >= 3'd4) && (32'(clique_size) <= MAX_CLIQUE)
                       && (nv >= {4'd0, clique_size});
   assign load_ok = cmd.load && ({1'b0, req_item.row_index} < 7'(MAX_VERTICES));

   assign cur_cand   = cand_ff[depth_ff];
   assign any_cand   = |cur_cand;
   assign lowest_bit = cur_cand & (~cur_cand + 64'd1);

   always_comb begin
      lowest_idx = '0;
      for (int i = 0; i < RowWidth; i++)
         if (lowest_bit[i]) lowest_idx = 6'(i);
   end

   assign above = (lowest_idx == 6'd63) ? '0 : ({RowWidth{1'b1}} << (lowest_idx + 6'd1));

   // rows never loaded read as zero
   assign row_use = row_ok_ff ? row_rd_ff : '0;

   assign sts.valid_size  = valid_size;
   assign sts.hit         = ({{(8-DW){1'b0}}, depth_ff} == {5'd0, clique_size});
   assign sts.exhausted   = (depth_ff == '0) && !any_cand && !row_pending_ff;
   assign sts.commit_done = ({{(8-DW){1'b0}}, cidx_ff} == {5'd0, clique_size});

   always_ff @(posedge clock) begin
      if (load_ok)
         rows_mem[req_item.row_index[VW-1:0]] <= req_item.row_bits;
      row_rd_ff <= rows_mem[lowest_idx[VW-1:0]];
      row_ok_ff <= rows_valid_ff[lowest_idx[VW-1:0]];
   end

   always_comb begin
      labelled_in = labelled_ff;
      if (load_ok)
         labelled_in[req_item.row_index[VW-1:0]] = 1'b0;
      if (cmd.commit && !sts.commit_done && label_ff != 6'd0)
         labelled_in[pick_ff[cidx_ff][VW-1:0]] = 1'b1;
   end

   assign depth_in = depth_ff + DW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         labelled_ff    <= '0;
         rows_valid_ff  <= '0;
         depth_ff       <= '0;
         row_pending_ff <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
         cidx_ff        <= '0;
      end else begin
         labelled_ff   <= labelled_in;
         rsp_strobe_ff <= cmd.respond;
         if (load_ok) rows_valid_ff[req_item.row_index[VW-1:0]] <= 1'b1;
         if (cmd.init) begin
            for (int i = 0; i < RowWidth; i++)
               cand_ff[0][i] <= (i < MAX_VERTICES) && (7'(i) < nv)
                                && !labelled_ff[i % MAX_VERTICES];
            depth_ff       <= '0;
            row_pending_ff <= 1'b0;
            cidx_ff        <= '0;
            label_ff       <= req_item.label;
         end else if (cmd.step) begin
            if (row_pending_ff) begin
               // descend with row of picked vertex
               cand_ff[depth_in] <= cand_ff[depth_in]
                  & (edge_color ? row_use : ~row_use);
               depth_ff       <= depth_in;
               row_pending_ff <= 1'b0;
            end else if (any_cand) begin
               pick_ff[depth_ff] <= lowest_idx;
               cand_ff[depth_ff] <= cur_cand & ~lowest_bit;
               cand_ff[depth_in] <= cur_cand & above;
               row_pending_ff    <= 1'b1;
            end else if (depth_ff != '0) begin
               depth_ff <= depth_ff - DW'(1);
            end
         end else if (cmd.commit && !sts.commit_done) begin
            cidx_ff <= cidx_ff + DW'(1);
         end
      end
   end

   always_comb begin
      rsp_in = '0;
      if (!cmd.fail) begin
         rsp_in.found        = 1'b1;
         rsp_in.member_count = clique_size;
         rsp_in.member_a     = pick_ff[0];
         rsp_in.member_b     = pick_ff[1];
         rsp_in.member_c     = pick_ff[2];
         rsp_in.member_d     = pick_ff[3];
         if (clique_size >= 3'd5) rsp_in.member_e = pick_ff[4 % MAX_CLIQUE];
         if (clique_size >= 3'd6) rsp_in.member_f = pick_ff[5 % MAX_CLIQUE];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ===== rtl/dcf_ctrl.sv =====
module dcf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 op,
   input  dcf_pkg::dcf_sts_type sts,
   output dcf_pkg::dcf_cmd_type cmd,
   output logic                 busy
);
   import dcf_pkg::*;

   typedef enum logic [2:0] {
      IDLE, SEARCH, COMMIT, RESPOND
   } state_type;

   state_type state_ff;
   logic      found_ff;

   always_comb begin
      cmd = '0;
      cmd.load    = (state_ff == IDLE) && start && (op == OpLoad);
      cmd.init    = (state_ff == IDLE) && start && (op == OpSearch);
      cmd.step    = (state_ff == SEARCH) && !sts.hit && !sts.exhausted;
      cmd.commit  = (state_ff == COMMIT);
      cmd.respond = cmd.load || (state_ff == RESPOND);
      cmd.fail    = cmd.load || !found_ff;
   end

   assign busy = (state_ff != IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         found_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (start && op == OpSearch) begin
                  found_ff <= 1'b0;
                  state_ff <= sts.valid_size ? SEARCH : RESPOND;
               end
            end
            SEARCH: begin
               if (sts.hit) begin
                  found_ff <= 1'b1;
                  state_ff <= COMMIT;
               end else if (sts.exhausted) begin
                  state_ff <= RESPOND;
               end
            end
            COMMIT:  if (sts.commit_done) state_ff <= RESPOND;
            RESPOND: state_ff <= IDLE;
            default: state_ff <= IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/disjoint_clique_finder_top.sv =====
// Greedy disjoint clique search. A load item (op 0) writes one adjacency row
// and clears that vertex's label; its result appears in the cycle after start. A
// search item (op 1), when clique size and vertex count allow, walks ascending
// vertex tuples depth first: a pick step, then a descend step that uses the
// registered row read from the adjacency memory, or a backtrack step; then it
// marks the members labelled (not for label 0) and reports. The total depends
// on graph density. busy drops in the cycle that rsp_valid pulses; rsp_valid is
// high for a single cycle and rsp_item holds the result until the next one.
module disjoint_clique_finder_top #(
   parameter int MAX_VERTICES = dcf_pkg::MaxVertices,
   parameter int MAX_CLIQUE   = dcf_pkg::MaxClique
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  dcf_pkg::req_type req_item,
   output logic             rsp_valid,
   output dcf_pkg::rsp_type rsp_item,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [6:0]       csr_data
);
   import dcf_pkg::*;

   logic [2:0]  clique_size_ff;
   logic [6:0]  vertex_count_ff;
   logic        edge_color_ff;
   dcf_cmd_type cmd;
   dcf_sts_type sts;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clique_size_ff  <= 3'd4;
         vertex_count_ff <= 7'd64;
         edge_color_ff   <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CsrCliqueSize:  clique_size_ff  <= csr_data[2:0];
            CsrVertexCount: vertex_count_ff <= csr_data;
            CsrEdgeColor:   edge_color_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   dcf_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .op(req_item.op),
      .sts(sts), .cmd(cmd), .busy(busy)
   );

   dcf_datapath #(.MAX_VERTICES(MAX_VERTICES), .MAX_CLIQUE(MAX_CLIQUE)) u_dp (
      .clock(clock), .reset(reset), .req_item(req_item),
      .clique_size(clique_size_ff), .vertex_count(vertex_count_ff),
      .edge_color(edge_color_ff), .cmd(cmd), .sts(sts),
      .rsp_strobe(rsp_valid), .rsp_item(rsp_item)
   );

`ifndef SYNTH
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.op == OpSearch) |=> busy)
      else $error("search did not raise busy");
   a_start_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.op == OpLoad) |=> rsp_valid)
      else $error("load result missing");
   a_found_cnt: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.found) |-> (rsp_item.member_count >= 3'd4))
      else $error("bad member count");
`endif

endmodule

// ===== test/disjoint_clique_finder_top_tb.sv =====
module disjoint_clique_finder_top_tb;
   import dcf_pkg::*;

   localparam int CycleLimit = 20_000_000;
   localparam int ItemTarget = 1850;

   class clique_board;
      logic [63:0] rows [MaxVertices];
      logic [5:0]  labels [MaxVertices];
      int unsigned csize;
      int unsigned vcount;
      bit          color;
      int          pick [MaxClique];
      rsp_type     awaited [$];
      int          errors;

      function void clear();
         foreach (rows[i]) begin
            rows[i] = '0;
            labels[i] = '0;
         end
         csize = 4;
         vcount = 64;
         color = 1'b1;
      endfunction

      function void note_config(logic [1:0] idx, logic [6:0] data);
         case (idx)
            CsrCliqueSize:  csize = 32'(data[2:0]);
            CsrVertexCount: vcount = 32'(data);
            CsrEdgeColor:   color = data[0];
            default: ;
         endcase
      endfunction

      function logic [63:0] color_row(int v);
         return color ? rows[v] : ~rows[v];
      endfunction

      // depth first, lowest vertex first, so the first hit is lexicographically first
      function bit grow(int depth, int need, logic [63:0] cand);
         logic [63:0] higher;
         if (depth >= need) return 1'b1;
         for (int v = 0; v < 64; v++) begin
            if (cand[v]) begin
               pick[depth] = v;
               higher = (v >= 63) ? 64'd0 : ({64{1'b1}} << (v + 1));
               if (grow(depth + 1, need, cand & higher & color_row(v))) return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function void note_item(req_type r);
         rsp_type     res;
         logic [5:0]  mem [MaxClique];
         int          nv;
         logic [63:0] cand;
         res = '0;
         if (r.op == OpLoad) begin
            rows[r.row_index] = r.row_bits;
            labels[r.row_index] = '0;
         end else begin
            nv = (vcount > MaxVertices) ? MaxVertices : int'(vcount);
            if (csize >= 4 && csize <= MaxClique && nv >= csize) begin
               cand = '0;
               for (int k = 0; k < nv; k++) cand[k] = (labels[k] == 0);
               if (grow(0, csize, cand)) begin
                  foreach (mem[k]) mem[k] = '0;
                  for (int k = 0; k < csize; k++) begin
                     labels[pick[k]] = r.label;
                     mem[k] = 6'(pick[k]);
                  end
                  res.found = 1'b1;
                  res.member_count = 3'(csize);
                  res.member_a = mem[0];
                  res.member_b = mem[1];
                  res.member_c = mem[2];
                  res.member_d = mem[3];
                  res.member_e = mem[4];
                  res.member_f = mem[5];
               end
            end
         end
         awaited.push_back(res);
      endfunction

      function void check(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", got);
            return;
         end
         want = awaited.pop_front();
         if (got.found !== want.found || got.member_count !== want.member_count ||
             got.member_a !== want.member_a || got.member_b !== want.member_b ||
             got.member_c !== want.member_c || got.member_d !== want.member_d ||
             got.member_e !== want.member_e || got.member_f !== want.member_f) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch: expected f=%0d n=%0d %0d %0d %0d %0d %0d %0d",
                  want.found, want.member_count, want.member_a, want.member_b,
                  want.member_c, want.member_d, want.member_e, want.member_f);
               $display("          got f=%0d n=%0d %0d %0d %0d %0d %0d %0d",
                  got.found, got.member_count, got.member_a, got.member_b,
                  got.member_c, got.member_d, got.member_e, got.member_f);
            end
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   req_type    req_item;
   logic       rsp_valid;
   rsp_type    rsp_item;
   logic       csr_valid;
   logic       csr_ready;
   logic [1:0] csr_index;
   logic [6:0] csr_data;

   clique_board board;
   int          cycles = 0;
   int          sent;
   bit          gaps_on;

   disjoint_clique_finder_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_item(rsp_item), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // results live one cycle, so sample mid-cycle
   always @(negedge clock) begin
      if (!reset && rsp_valid) board.check(rsp_item);
   end

   task automatic send_item(req_type r);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= r;
      forever begin
         @(negedge clock);
         if (!busy) break;
      end
      @(posedge clock);
      board.note_item(r);
      sent++;
   endtask

   task automatic write_reg(logic [1:0] idx, logic [6:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      forever begin
         @(negedge clock);
         if (csr_ready) break;
      end
      @(posedge clock);
      board.note_config(idx, data);
   endtask

   // block must be idle before registers change
   task automatic drain();
      start <= 1'b0;
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(int sz, int vc, bit col);
      drain();
      write_reg(CsrCliqueSize, {4'($urandom_range(0, 15)), 3'(sz)});
      write_reg(CsrVertexCount, 7'(vc));
      write_reg(CsrEdgeColor, {6'($urandom_range(0, 63)), col});
      if ($urandom_range(0, 9) == 0) write_reg(2'd3, 7'($urandom_range(0, 127)));
      csr_valid <= 1'b0;
   endtask

   task automatic load_row(int v, logic [63:0] bits);
      req_type r;
      r = '0;
      r.op = OpLoad;
      r.row_index = 6'(v);
      r.row_bits = bits;
      r.label = 6'($urandom_range(0, 63));
      send_item(r);
   endtask

   task automatic search(int lab);
      req_type r;
      r.op = OpSearch;
      r.row_index = 6'($urandom_range(0, 63));
      r.row_bits = {$urandom, $urandom};
      r.label = 6'(lab);
      send_item(r);
   endtask

   initial begin
      int          sz;
      int          vc;
      int          pct;
      int          nv;
      bit          col;
      logic [63:0] bits;
      board = new();
      board.clear();
      sent = 0;
      gaps_on = 1'b1;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: full rows give a clique, zero rows only under the inverted color
      for (int v = 0; v < 4; v++) load_row(v, {64{1'b1}});
      load_row(63, {64{1'b1}});
      search(63);
      search(5);
      configure(4, 64, 1'b0);
      search(0);
      search(0);
      load_row(2, 64'd0);
      search(1);
      configure(7, 64, 1'b0);
      search(2);
      configure(3, 64, 1'b0);
      search(2);
      configure(0, 64, 1'b0);
      search(2);
      configure(6, 127, 1'b0);
      search(7);
      search(8);
      configure(5, 3, 1'b0);
      search(9);
      configure(6, 0, 1'b1);
      search(10);
      configure(6, 64, 1'b1);
      search(11);

      while (sent < ItemTarget) begin
         if (sent > ItemTarget * 85 / 100) gaps_on = 1'b0;
         case ($urandom_range(0, 19))
            0:       sz = $urandom_range(0, 7);
            default: sz = $urandom_range(4, 6);
         endcase
         case ($urandom_range(0, 19))
            0:       vc = $urandom_range(0, 5);
            1:       vc = 64;
            2:       vc = $urandom_range(65, 127);
            default: vc = $urandom_range(6, 12);
         endcase
         col = $urandom_range(0, 1);
         configure(sz, vc, col);
         nv = (vc > 64) ? 64 : vc;
         // large graphs stay dense so the search ends quickly
         if (nv > 12) pct = 90;
         else case ($urandom_range(0, 2))
            0:       pct = 15;
            1:       pct = 50;
            default: pct = 90;
         endcase
         for (int v = 0; v < nv; v++) begin
            for (int j = 0; j < 64; j++) bits[j] = ($urandom_range(0, 99) < pct) ? col : ~col;
            load_row(v, bits);
         end
         repeat ($urandom_range(0, 2)) load_row($urandom_range(0, 63), {$urandom, $urandom});
         repeat ($urandom_range(1, 8)) begin
            search(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 63));
            if ($urandom_range(0, 9) == 0) begin
               for (int j = 0; j < 64; j++) bits[j] = ($urandom_range(0, 99) < pct) ? col : ~col;
               load_row($urandom_range(0, nv > 0 ? nv - 1 : 0), bits);
            end
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (board.errors == 0 && board.awaited.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/dcf_pkg.sv
rtl/dcf_datapath.sv
rtl/dcf_ctrl.sv
rtl/disjoint_clique_finder_top.sv
test/disjoint_clique_finder_top_tb.sv
